>>> src/int32_dequant_scale_bias_assert.svh
// Assertion macros used by the dequantizer top level.
`ifndef INT32_DEQUANT_SCALE_BIAS_ASSERT_SVH
`define INT32_DEQUANT_SCALE_BIAS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DQS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dqs_pkg.sv
// Shared types, constants and binary32 helper functions of the dequantizer.
package dqs_pkg;

    localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
    localparam logic [31:0] MSCALE_RESET = 32'h3F80_0000;

    typedef enum logic [1:0] {
        CFG_HAS_BIAS  = 2'd0,
        CFG_PER_COL   = 2'd1,
        CFG_ACCUM     = 2'd2,
        CFG_MSCALE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FC_NUM,
        FC_NAN,
        FC_INF,
        FC_PASS
    } t_fcls;

    // Load enables of a two-stage arithmetic unit.
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_adv;

    typedef struct packed {
        logic [47:0] sig;
        logic [5:0]  lz;
    } t_norm;

    // Shifts a nonzero word left until its top bit is set.
    function automatic t_norm f_norm48(input logic [47:0] s);
        t_norm r;
        r.sig = s;
        r.lz  = '0;
        if (r.sig[47:16] == 32'd0) begin
            r.sig = {r.sig[15:0], 32'd0};
            r.lz[5] = 1'b1;
        end
        if (r.sig[47:32] == 16'd0) begin
            r.sig = {r.sig[31:0], 16'd0};
            r.lz[4] = 1'b1;
        end
        if (r.sig[47:40] == 8'd0) begin
            r.sig = {r.sig[39:0], 8'd0};
            r.lz[3] = 1'b1;
        end
        if (r.sig[47:44] == 4'd0) begin
            r.sig = {r.sig[43:0], 4'd0};
            r.lz[2] = 1'b1;
        end
        if (r.sig[47:46] == 2'd0) begin
            r.sig = {r.sig[45:0], 2'd0};
            r.lz[1] = 1'b1;
        end
        if (r.sig[47] == 1'b0) begin
            r.sig = {r.sig[46:0], 1'b0};
            r.lz[0] = 1'b1;
        end
        return r;
    endfunction

    // Rounds a normalized significand (top bit at 47) with biased exponent be
    // to nearest even, producing subnormals and infinities as needed.
    function automatic logic [31:0] f_round_pack(input logic sgn,
                                                 input logic signed [11:0] be,
                                                 input logic [47:0] sig);
        logic [47:0] sh;
        logic        extra;
        logic [11:0] amt;
        logic        g;
        logic        st;
        logic        inc;
        logic [24:0] m25;
        logic [11:0] e;
        if (be < 12'sd1) begin
            amt = 12'(12'sd1 - be);
            if (amt >= 12'd48) begin
                sh    = '0;
                extra = |sig;
            end else begin
                sh    = sig >> amt[5:0];
                extra = |(sig & ~({48{1'b1}} << amt[5:0]));
            end
        end else begin
            amt   = '0;
            sh    = sig;
            extra = 1'b0;
        end
        g   = sh[23];
        st  = (|sh[22:0]) | extra;
        inc = g & (st | sh[24]);
        m25 = {1'b0, sh[47:24]} + 25'(inc);
        if (be < 12'sd1) begin
            e = {11'd0, m25[23]};
        end else begin
            e = 12'(be) + {11'd0, m25[24]};
        end
        if (e >= 12'd255) begin
            return {sgn, 8'hFF, 23'd0};
        end
        return {sgn, e[7:0], m25[22:0]};
    endfunction

endpackage

>>> src/dqs_req_if.sv
// Request channel carrying one accumulator and its column operands.
interface dqs_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] acc;
    logic [31:0] col_scale;
    logic [31:0] col_bias;
    logic [31:0] prior_out;

    modport source (output valid, acc, col_scale, col_bias, prior_out, input ready);
    modport sink   (input valid, acc, col_scale, col_bias, prior_out, output ready);
endinterface

>>> src/dqs_rsp_if.sv
// Response channel carrying one binary32 result.
interface dqs_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_value;

    modport source (output valid, out_value, input ready);
    modport sink   (input valid, out_value, output ready);
endinterface

>>> src/dqs_i2f.sv
// Single-stage signed 32-bit integer to binary32 conversion.
module dqs_i2f (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_acc,
    output logic [31:0] o_value
);
    logic [31:0]       w_mag;
    dqs_pkg::t_norm    w_norm;
    logic signed [11:0] w_be;
    logic [31:0]       n_value;
    logic [31:0]       r_value;

    always_comb begin
        w_mag  = i_acc[31] ? (~i_acc + 32'd1) : i_acc;
        w_norm = dqs_pkg::f_norm48({w_mag, 16'd0});
        w_be   = 12'sd158 - $signed({6'd0, w_norm.lz});
        if (w_mag == 32'd0) begin
            n_value = 32'd0;
        end else begin
            n_value = dqs_pkg::f_round_pack(i_acc[31], w_be, w_norm.sig);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
endmodule

>>> src/dqs_fmul.sv
// Two-stage binary32 multiplier: significand product, then normalize and round.
module dqs_fmul (
    input  logic          i_clk,
    input  dqs_pkg::t_adv i_adv,
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    output logic [31:0]   o_value
);
    logic               w_anan, w_bnan, w_ainf, w_binf, w_azero, w_bzero;
    logic [23:0]        w_ma, w_mb;
    logic [7:0]         w_ea, w_eb;
    dqs_pkg::t_fcls     n_cls;
    dqs_pkg::t_fcls     r_cls;
    logic               r_zero;
    logic               r_sign;
    logic signed [11:0] r_esum;
    logic [47:0]        r_prod;
    dqs_pkg::t_norm     w_norm;
    logic [31:0]        n_value;
    logic [31:0]        r_value;

    always_comb begin
        w_anan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        w_bnan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        w_ainf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        w_binf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        w_azero = (i_a[30:0] == 31'd0);
        w_bzero = (i_b[30:0] == 31'd0);
        w_ma    = {i_a[30:23] != 8'd0, i_a[22:0]};
        w_mb    = {i_b[30:23] != 8'd0, i_b[22:0]};
        w_ea    = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        w_eb    = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        if (w_anan || w_bnan || (w_ainf && w_bzero) || (w_binf && w_azero)) begin
            n_cls = dqs_pkg::FC_NAN;
        end else if (w_ainf || w_binf) begin
            n_cls = dqs_pkg::FC_INF;
        end else begin
            n_cls = dqs_pkg::FC_NUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.en_a) begin
            r_cls  <= n_cls;
            r_zero <= w_azero || w_bzero;
            r_sign <= i_a[31] ^ i_b[31];
            r_esum <= $signed({4'd0, w_ea}) + $signed({4'd0, w_eb}) - 12'sd126;
            r_prod <= w_ma * w_mb;
        end
    end

    always_comb begin
        w_norm = dqs_pkg::f_norm48(r_prod);
        case (r_cls)
            dqs_pkg::FC_NAN: n_value = dqs_pkg::CANON_NAN;
            dqs_pkg::FC_INF: n_value = {r_sign, 8'hFF, 23'd0};
            default: begin
                if (r_zero) begin
                    n_value = {r_sign, 31'd0};
                end else begin
                    n_value = dqs_pkg::f_round_pack(r_sign,
                                  r_esum - $signed({6'd0, w_norm.lz}), w_norm.sig);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.en_b) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
endmodule

>>> src/dqs_fadd.sv
// Two-stage binary32 adder with bypass: align and add, then normalize and round.
module dqs_fadd (
    input  logic          i_clk,
    input  dqs_pkg::t_adv i_adv,
    input  logic          i_use,
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    output logic [31:0]   o_value
);
    logic               w_anan, w_bnan, w_ainf, w_binf;
    logic [31:0]        w_x, w_y;
    logic [7:0]         w_ex, w_ey, w_d;
    logic [23:0]        w_mx, w_my;
    logic [47:0]        w_yfull, w_ysh;
    logic               w_stk;
    logic [48:0]        w_xx, w_yy;
    dqs_pkg::t_fcls     n_cls;
    logic               n_sign;
    dqs_pkg::t_fcls     r_cls;
    logic               r_sign;
    logic               r_zsign;
    logic [7:0]         r_ex;
    logic [48:0]        r_sum;
    logic [31:0]        r_pass;
    dqs_pkg::t_norm     w_norm;
    logic [47:0]        w_sig;
    logic signed [11:0] w_be;
    logic [31:0]        n_value;
    logic [31:0]        r_value;

    always_comb begin
        w_anan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        w_bnan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        w_ainf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        w_binf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        n_sign = i_a[31];
        if (!i_use) begin
            n_cls = dqs_pkg::FC_PASS;
        end else if (w_anan || w_bnan || (w_ainf && w_binf && (i_a[31] != i_b[31]))) begin
            n_cls = dqs_pkg::FC_NAN;
        end else if (w_ainf) begin
            n_cls = dqs_pkg::FC_INF;
        end else if (w_binf) begin
            n_cls  = dqs_pkg::FC_INF;
            n_sign = i_b[31];
        end else begin
            n_cls = dqs_pkg::FC_NUM;
        end
        // The operand of larger magnitude sets the exponent and the sign.
        if (i_a[30:0] >= i_b[30:0]) begin
            w_x = i_a;
            w_y = i_b;
        end else begin
            w_x = i_b;
            w_y = i_a;
        end
        if (n_cls == dqs_pkg::FC_NUM) begin
            n_sign = w_x[31];
        end
        w_ex    = (w_x[30:23] == 8'd0) ? 8'd1 : w_x[30:23];
        w_ey    = (w_y[30:23] == 8'd0) ? 8'd1 : w_y[30:23];
        w_mx    = {w_x[30:23] != 8'd0, w_x[22:0]};
        w_my    = {w_y[30:23] != 8'd0, w_y[22:0]};
        w_d     = w_ex - w_ey;
        w_yfull = {w_my, 24'd0};
        if (w_d >= 8'd48) begin
            w_ysh = '0;
            w_stk = |w_my;
        end else begin
            w_ysh = w_yfull >> w_d[5:0];
            w_stk = |(w_yfull & ~({48{1'b1}} << w_d[5:0]));
        end
        w_xx = {1'b0, w_mx, 24'd0};
        w_yy = {1'b0, w_ysh[47:1], w_ysh[0] | w_stk};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.en_a) begin
            r_cls   <= n_cls;
            r_sign  <= n_sign;
            r_zsign <= (w_x[31] == w_y[31]) ? w_x[31] : 1'b0;
            r_ex    <= w_ex;
            r_sum   <= (w_x[31] != w_y[31]) ? (w_xx - w_yy) : (w_xx + w_yy);
            r_pass  <= i_a;
        end
    end

    always_comb begin
        w_norm = dqs_pkg::f_norm48(r_sum[47:0]);
        if (r_sum[48]) begin
            w_sig = {r_sum[48:2], r_sum[1] | r_sum[0]};
            w_be  = $signed({4'd0, r_ex}) + 12'sd1;
        end else begin
            w_sig = w_norm.sig;
            w_be  = $signed({4'd0, r_ex}) - $signed({6'd0, w_norm.lz});
        end
        case (r_cls)
            dqs_pkg::FC_PASS: n_value = r_pass;
            dqs_pkg::FC_NAN:  n_value = dqs_pkg::CANON_NAN;
            dqs_pkg::FC_INF:  n_value = {r_sign, 8'hFF, 23'd0};
            default: begin
                // Exact cancellation and sums of zeros come out as zero.
                if (r_sum == 49'd0) begin
                    n_value = {r_zsign, 31'd0};
                end else begin
                    n_value = dqs_pkg::f_round_pack(r_sign, w_be, w_sig);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.en_b) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
endmodule

>>> src/int32_dequant_scale_bias.sv
// Top level of the int32 to binary32 dequantizer with scale, bias and accumulate.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    acc, col_scale, col_bias, prior_out
//  o_rsp     out  valid/ready    out_value
//  i_cfg_*   in   write enable   index, 32-bit data
//
// Seven register stages: convert, multiply (2), bias add (2), prior add (2).
// One request enters per cycle unless a stalled output has filled every stage.
// Each stage holds its own valid bit and loads when it is empty or moving on,
// so bubbles close up and a stalled output halts only the full stages.
// Reset clears the valid bits and configuration; matrix_scale resets to 1.0.
`include "int32_dequant_scale_bias_assert.svh"

module int32_dequant_scale_bias (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqs_req_if.sink     i_req,
    dqs_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    logic        r_has_bias;
    logic        r_per_col;
    logic        r_accum;
    logic [31:0] r_mscale;

    logic [6:0]  r_v;
    logic [6:0]  w_en;

    logic [31:0] r_s0_scale;
    logic [31:0] r_s0_bias, r_s1_bias, r_s2_bias;
    logic [31:0] r_s0_prior, r_s1_prior, r_s2_prior, r_s3_prior, r_s4_prior;

    logic [31:0] w_conv, w_prod, w_biased, w_result;
    dqs_pkg::t_adv w_mul_adv, w_bias_adv, w_acc_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_bias <= 1'b0;
            r_per_col  <= 1'b0;
            r_accum    <= 1'b0;
            r_mscale   <= dqs_pkg::MSCALE_RESET;
        end else if (i_cfg_we) begin
            case (dqs_pkg::t_cfg_idx'(i_cfg_idx))
                dqs_pkg::CFG_HAS_BIAS: r_has_bias <= i_cfg_data[0];
                dqs_pkg::CFG_PER_COL:  r_per_col  <= i_cfg_data[0];
                dqs_pkg::CFG_ACCUM:    r_accum    <= i_cfg_data[0];
                dqs_pkg::CFG_MSCALE:   r_mscale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_en[6] = !r_v[6] || o_rsp.ready;
        for (int k = 5; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_scale <= r_per_col ? i_req.col_scale : r_mscale;
            r_s0_bias  <= i_req.col_bias;
            r_s0_prior <= i_req.prior_out;
        end
        if (w_en[1]) begin
            r_s1_bias  <= r_s0_bias;
            r_s1_prior <= r_s0_prior;
        end
        if (w_en[2]) begin
            r_s2_bias  <= r_s1_bias;
            r_s2_prior <= r_s1_prior;
        end
        if (w_en[3]) begin
            r_s3_prior <= r_s2_prior;
        end
        if (w_en[4]) begin
            r_s4_prior <= r_s3_prior;
        end
    end

    assign w_mul_adv  = '{en_a: w_en[1], en_b: w_en[2]};
    assign w_bias_adv = '{en_a: w_en[3], en_b: w_en[4]};
    assign w_acc_adv  = '{en_a: w_en[5], en_b: w_en[6]};

    dqs_i2f u_i2f (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_acc   (i_req.acc),
        .o_value (w_conv)
    );

    dqs_fmul u_mul (
        .i_clk   (i_clk),
        .i_adv   (w_mul_adv),
        .i_a     (w_conv),
        .i_b     (r_s0_scale),
        .o_value (w_prod)
    );

    dqs_fadd u_bias (
        .i_clk   (i_clk),
        .i_adv   (w_bias_adv),
        .i_use   (r_has_bias),
        .i_a     (w_prod),
        .i_b     (r_s2_bias),
        .o_value (w_biased)
    );

    dqs_fadd u_accum (
        .i_clk   (i_clk),
        .i_adv   (w_acc_adv),
        .i_use   (r_accum),
        .i_a     (w_biased),
        .i_b     (r_s4_prior),
        .o_value (w_result)
    );

    assign i_req.ready     = w_en[0];
    assign o_rsp.valid     = r_v[6];
    assign o_rsp.out_value = w_result;

    `DQS_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_req.valid && i_req.ready, r_v[0],
        "accepted request did not enter the first stage")
    `DQS_ASSERT_NOW(a_full_when_blocked, i_clk, i_rst_n, !i_req.ready, &r_v,
        "request blocked while a pipeline stage is empty")
    `DQS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready,
        o_rsp.valid && $stable(o_rsp.out_value), "stalled result changed or vanished")
    `DQS_ASSERT_NOW(a_nan_canonical, i_clk, i_rst_n,
        o_rsp.valid && (o_rsp.out_value[30:23] == 8'hFF) && (o_rsp.out_value[22:0] != 23'd0),
        o_rsp.out_value == dqs_pkg::CANON_NAN, "result NaN is not canonical")
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the int32 to binary32 dequantizer with scale, bias and accumulate.
module tb;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    dqs_req_if req_ch ();
    dqs_rsp_if rsp_ch ();

    int32_dequant_scale_bias u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Bit-exact binary32 arithmetic with round to nearest even, and the queue of
    // dequantized values still owed by the block.
    class dequant_scoreboard;
        bit          add_bias;
        bit          col_scaled;
        bit          accum_mode;
        bit [31:0]   mat_scale;
        bit [31:0]   owed_values[$];
        int          mismatches;

        function new();
            add_bias   = 1'b0;
            col_scaled = 1'b0;
            accum_mode = 1'b0;
            mat_scale  = dqs_pkg::MSCALE_RESET;
            mismatches = 0;
        endfunction

        // Rounds the exact value m * 2^e (m nonzero) to binary32.
        function bit [31:0] round_to_single(bit s, int e, bit [63:0] m);
            int        msb;
            int        lsb_exp;
            int        sh;
            bit [63:0] q;
            bit        g;
            bit        st;
            msb = 63;
            while (!m[msb]) msb--;
            lsb_exp = msb + e - 23;
            if (lsb_exp < -149) lsb_exp = -149;
            sh = lsb_exp - e;
            if (sh <= 0) begin
                q = m << (-sh);
                g = 1'b0;
                st = 1'b0;
            end else if (sh > 64) begin
                q = '0;
                g = 1'b0;
                st = 1'b1;
            end else if (sh == 64) begin
                q = '0;
                g = m[63];
                st = |(m << 1);
            end else begin
                q = m >> sh;
                g = m[sh-1];
                st = (sh > 1) ? |(m << (65 - sh)) : 1'b0;
            end
            if (g && (st || q[0])) q++;
            if (q[24]) begin
                q = q >> 1;
                lsb_exp++;
            end
            if (q == 0) return {s, 31'd0};
            if (!q[23]) return {s, 8'd0, q[22:0]};
            if (lsb_exp + 150 >= 255) return {s, 8'hFF, 23'd0};
            return {s, 8'(lsb_exp + 150), q[22:0]};
        endfunction

        function bit is_nan(bit [31:0] x);
            return (x[30:23] == 8'hFF) && (x[22:0] != 0);
        endfunction

        function bit is_inf(bit [31:0] x);
            return (x[30:23] == 8'hFF) && (x[22:0] == 0);
        endfunction

        function bit is_zero(bit [31:0] x);
            return x[30:0] == 0;
        endfunction

        function void split(bit [31:0] x, output int e, output bit [63:0] m);
            if (x[30:23] == 0) begin
                m = {41'd0, x[22:0]};
                e = -149;
            end else begin
                m = {40'd0, 1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        function bit [31:0] int_to_single(bit [31:0] a);
            bit [63:0] mag;
            if (a == 0) return 32'd0;
            mag = a[31] ? (64'(-{32'd0, a}) & 64'hFFFF_FFFF) : {32'd0, a};
            return round_to_single(a[31], 0, mag);
        endfunction

        function bit [31:0] mul_single(bit [31:0] a, bit [31:0] b);
            int        ea;
            int        eb;
            bit [63:0] ma;
            bit [63:0] mb;
            bit        s;
            s = a[31] ^ b[31];
            if (is_nan(a) || is_nan(b)) return dqs_pkg::CANON_NAN;
            if (is_inf(a) || is_inf(b)) begin
                if (is_zero(a) || is_zero(b)) return dqs_pkg::CANON_NAN;
                return {s, 8'hFF, 23'd0};
            end
            if (is_zero(a) || is_zero(b)) return {s, 31'd0};
            split(a, ea, ma);
            split(b, eb, mb);
            return round_to_single(s, ea + eb, ma * mb);
        endfunction

        function bit [31:0] add_single(bit [31:0] a, bit [31:0] b);
            int        ea;
            int        eb;
            int        d;
            bit [63:0] ma;
            bit [63:0] mb;
            bit [63:0] lo;
            bit [63:0] r;
            bit [31:0] t;
            bit        s;
            if (is_nan(a) || is_nan(b)) return dqs_pkg::CANON_NAN;
            if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return dqs_pkg::CANON_NAN;
            if (is_inf(a)) return a;
            if (is_inf(b)) return b;
            if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
            if (is_zero(a)) return b;
            if (is_zero(b)) return a;
            if (a[30:0] < b[30:0]) begin
                t = a;
                a = b;
                b = t;
            end
            split(a, ea, ma);
            split(b, eb, mb);
            ma = ma << 30;
            mb = mb << 30;
            d = ea - eb;
            if (d >= 62) lo = 64'd1;
            else lo = (mb >> d) | 64'(|(mb & ((64'd1 << d) - 64'd1)));
            if (a[31] == b[31]) begin
                r = ma + lo;
                s = a[31];
            end else begin
                r = ma - lo;
                s = a[31];
            end
            if (r == 0) return 32'd0;
            return round_to_single(s, ea - 30, r);
        endfunction

        function void note_request(bit [31:0] acc, bit [31:0] cs, bit [31:0] cb,
                                   bit [31:0] po);
            bit [31:0] v;
            v = mul_single(int_to_single(acc), col_scaled ? cs : mat_scale);
            if (add_bias) v = add_single(v, cb);
            if (accum_mode) v = add_single(po, v);
            if (is_nan(v)) v = dqs_pkg::CANON_NAN;
            owed_values.push_back(v);
        endfunction

        function void check_result(bit [31:0] got);
            bit [31:0] want;
            if (owed_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result out_value=%h", got);
                return;
            end
            want = owed_values.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("out_value mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    dequant_scoreboard sb;
    int idle_cycles;
    int rdy_mode;
    int rdy_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stall pattern: the mode is redrawn at random each time rdy_count wraps to zero.
    always @(posedge i_clk) begin
        if (rdy_count == 0) rdy_mode <= $urandom_range(0, 3);
        rdy_count <= (rdy_count == 49) ? 0 : rdy_count + 1;
        case (rdy_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.acc, req_ch.col_scale, req_ch.col_bias,
                                req_ch.prior_out);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.out_value);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic cfg_write(dqs_pkg::t_cfg_idx idx, bit [31:0] d);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        case (idx)
            dqs_pkg::CFG_HAS_BIAS: sb.add_bias = d[0];
            dqs_pkg::CFG_PER_COL:  sb.col_scaled = d[0];
            dqs_pkg::CFG_ACCUM:    sb.accum_mode = d[0];
            default:               sb.mat_scale = d;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Holds one request on the channel until it is taken.
    task automatic send_request(bit [31:0] acc, bit [31:0] cs, bit [31:0] cb,
                                bit [31:0] po);
        req_ch.valid <= 1'b1;
        req_ch.acc <= acc;
        req_ch.col_scale <= cs;
        req_ch.col_bias <= cb;
        req_ch.prior_out <= po;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic pause_sender(int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_float();
        case ($urandom_range(0, 9))
            0: return {1'($urandom_range(0, 1)), 31'd0};
            1: return {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
            2: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
            3: return {1'($urandom_range(0, 1)), 8'd0, 23'($urandom)};
            4: return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 1) ? 8'hFE : 8'h01),
                       23'($urandom)};
            5, 6: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 150)),
                          23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] pick_acc();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(0, 64)) - 32);
            2: return (32'd1 << $urandom_range(24, 30)) | 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_traffic(int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                send_request(pick_acc(), pick_float(), pick_float(), pick_float());
                burst--;
                count--;
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
        end
    endtask

    typedef struct {
        bit [31:0] acc;
        bit [31:0] cs;
        bit [31:0] cb;
        bit [31:0] po;
    } t_case;

    t_case corner[15] = '{
        '{32'h7FFF_FFFF, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'h8000_0000, 32'h3F80_0000, 32'h8000_0000, 32'h8000_0000},
        '{32'h0000_0000, 32'h7F80_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_0001, 32'h7FC1_2345, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_0001, 32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000},
        '{32'h0100_0001, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'h7FFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_0001, 32'h0000_0001, 32'h8000_0001, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0080_0000, 32'h0000_0001, 32'h8000_0000},
        '{32'h0000_0003, 32'h3F00_0000, 32'hBFC0_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000},
        '{32'h0000_0005, 32'h4000_0000, 32'h4B80_0000, 32'h3F80_0000},
        '{32'h0000_3039, 32'h3DCC_CCCD, 32'hC2C8_0000, 32'h7F80_0000},
        '{32'hFFFF_FFF9, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'hFF80_0000},
        '{32'h0000_0064, 32'h3380_0000, 32'h0000_0000, 32'h3400_0000}
    };

    bit [31:0] scale_list[8] = '{32'h3F80_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000,
                                 32'hBF80_0000, 32'h3A83_126F};

    initial begin
        sb = new();
        i_clk = 1'b0;
        idle_cycles = 0;
        rdy_mode = 0;
        rdy_count = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = dqs_pkg::CFG_HAS_BIAS;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.acc = '0;
        req_ch.col_scale = '0;
        req_ch.col_bias = '0;
        req_ch.prior_out = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration first: plain conversion with a unit scale.
        random_traffic(20);
        drain();

        cfg_write(dqs_pkg::CFG_HAS_BIAS, 32'd1);
        cfg_write(dqs_pkg::CFG_PER_COL, 32'd1);
        cfg_write(dqs_pkg::CFG_ACCUM, 32'd1);
        cfg_done();
        foreach (corner[k]) send_request(corner[k].acc, corner[k].cs, corner[k].cb,
                                         corner[k].po);
        drain();

        for (int p = 0; p < 9; p++) begin
            cfg_write(dqs_pkg::CFG_HAS_BIAS, p[0] ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
            cfg_write(dqs_pkg::CFG_PER_COL, {31'($urandom), p[1]});
            cfg_write(dqs_pkg::CFG_ACCUM, {31'($urandom), p[2]});
            cfg_write(dqs_pkg::CFG_MSCALE, (p < 8) ? scale_list[p] : pick_float());
            cfg_done();
            random_traffic(35);
            // Let the pipeline empty completely in the middle of a setting.
            drain();
            random_traffic(35);
            drain();
        end

        if (sb.mismatches == 0 && sb.owed_values.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
